### rtl/stun_turn_tcp_deframer_top_defines.svh
// ----------------------------------------------------------------------------
// STUN/TURN TCP deframer assertion macros
// Shared concurrent check macros; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STUN_TURN_TCP_DEFRAMER_TOP_DEFINES_SVH
`define STUN_TURN_TCP_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds whenever ante holds, outside reset
`define STTD_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer check failed");

// Check that cons holds in the cycle after ante holds, outside reset
`define STTD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer check failed");

`else

`define STTD_ASSERT_IMP(label, ante, cons)
`define STTD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/sttd_pkg.sv
// ----------------------------------------------------------------------------
// STUN/TURN TCP deframer package
// Framing constants and the result item type of the deframer.
// ----------------------------------------------------------------------------
package sttd_pkg;

   localparam int ByteWidth   = 8;
   localparam int LengthWidth = 17;

   // Top two bits of the message type select ChannelData
   localparam logic [ByteWidth-1:0]   TypeClassMask      = 8'hC0;
   localparam logic [LengthWidth-1:0] StunHeaderBytes    = 17'd20;
   localparam logic [LengthWidth-1:0] ChannelHeaderBytes = 17'd4;
   localparam logic [LengthWidth-1:0] HeaderBytes        = 17'd4;
   localparam logic [LengthWidth-1:0] LengthHighPos      = 17'd2;
   localparam logic [LengthWidth-1:0] LengthLowPos       = 17'd3;

   typedef logic [ByteWidth-1:0]   byte_type;
   typedef logic [LengthWidth-1:0] length_type;

   typedef struct packed {
      byte_type   packet_byte;
      logic       packet_last;
      logic       is_channel_data;
      length_type frame_length;
   } result_type;

endpackage

### rtl/stun_turn_tcp_deframer_top.sv
// Takes a TCP byte stream one byte per cycle and splits it into STUN messages
// and TURN ChannelData packets. Every packet byte, header included, comes out
// as one result item; pad bytes after a ChannelData packet are consumed and
// give no result. The final byte of a packet carries packet_last and the frame
// length (packet plus pad). Sustained rate is one byte per clock while the
// result side keeps rsp_ready high; a byte's result is loaded into the result
// register when the byte advances from the input register, which waits while
// the result register holds an untaken result. Header decode and the 17-bit
// byte counter's end-of-packet compare lie combinationally between the two.
`include "stun_turn_tcp_deframer_top_defines.svh"
// ----------------------------------------------------------------------------
// STUN/TURN TCP deframer top level
// Streams packet bytes through and marks packet ends from the 4-byte header.
// ----------------------------------------------------------------------------
module stun_turn_tcp_deframer_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sttd_pkg::byte_type   req_stream_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sttd_pkg::byte_type   rsp_packet_byte,
   output logic                 rsp_packet_last,
   output logic                 rsp_is_channel_data,
   output sttd_pkg::length_type rsp_frame_length
);
   import sttd_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   byte_type   in_byte_ff, in_byte_in;

   // framing state
   byte_type   prev_byte_ff, prev_byte_in;
   length_type byte_position_ff, byte_position_in;
   length_type packet_total_ff, packet_total_in;
   logic [1:0] pad_remaining_ff, pad_remaining_in;
   logic       channel_flag_ff, channel_flag_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   // step logic
   logic       drop;
   logic       advance;
   logic       flag_next;
   length_type total_next;
   length_type pos_inc;
   logic       is_last;
   logic [1:0] pad;

   // Advance the held item when it is dropped or the result slot frees up
   assign drop      = (pad_remaining_ff != 2'd0);
   assign advance   = in_valid_ff && (drop || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Decode the header and find the packet end
   always_comb begin
      flag_next = channel_flag_ff;
      if (byte_position_ff == '0) begin
         flag_next = ((in_byte_ff & TypeClassMask) != '0);
      end
      total_next = packet_total_ff;
      if (byte_position_ff == LengthLowPos) begin
         total_next = {1'b0, prev_byte_ff, in_byte_ff}
                    + (flag_next ? ChannelHeaderBytes : StunHeaderBytes);
      end
      pos_inc = byte_position_ff + 17'd1;
      is_last = (pos_inc >= HeaderBytes) && (pos_inc == total_next);
      pad     = flag_next ? 2'(2'd0 - total_next[1:0]) : 2'd0;
   end

   // Next state of the input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_stream_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Next framing state and result
   always_comb begin
      prev_byte_in     = prev_byte_ff;
      byte_position_in = byte_position_ff;
      packet_total_in  = packet_total_ff;
      pad_remaining_in = pad_remaining_ff;
      channel_flag_in  = channel_flag_ff;
      out_valid_in     = out_valid_ff && !rsp_ready;
      out_in           = out_ff;
      if (advance) begin
         if (drop) begin
            pad_remaining_in = pad_remaining_ff - 2'd1;
         end else begin
            channel_flag_in  = flag_next;
            packet_total_in  = total_next;
            if (byte_position_ff <= LengthHighPos) begin
               prev_byte_in = in_byte_ff;
            end
            byte_position_in         = pos_inc;
            out_valid_in             = 1'b1;
            out_in.packet_byte       = in_byte_ff;
            out_in.packet_last       = is_last;
            out_in.is_channel_data   = flag_next;
            out_in.frame_length      = '0;
            if (is_last) begin
               out_in.frame_length = total_next + 17'(pad);
               pad_remaining_in    = pad;
               byte_position_in    = '0;
            end
         end
      end
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         prev_byte_ff     <= '0;
         byte_position_ff <= '0;
         packet_total_ff  <= '0;
         pad_remaining_ff <= 2'd0;
         channel_flag_ff  <= 1'b0;
      end else begin
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
         prev_byte_ff     <= prev_byte_in;
         byte_position_ff <= byte_position_in;
         packet_total_ff  <= packet_total_in;
         pad_remaining_ff <= pad_remaining_in;
         channel_flag_ff  <= channel_flag_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_packet_byte     = out_ff.packet_byte;
   assign rsp_packet_last     = out_ff.packet_last;
   assign rsp_is_channel_data = out_ff.is_channel_data;
   assign rsp_frame_length    = out_ff.frame_length;

   // ChannelData frames always close on a multiple of four
   `STTD_ASSERT_IMP(a_cd_aligned,
      out_valid_ff && out_ff.packet_last && out_ff.is_channel_data,
      out_ff.frame_length[1:0] == 2'd0)
   // Frame length only shows on the last byte
   `STTD_ASSERT_IMP(a_len_only_last,
      out_valid_ff && !out_ff.packet_last, out_ff.frame_length == '0)
   // STUN frames hold at least the fixed header
   `STTD_ASSERT_IMP(a_stun_min,
      out_valid_ff && out_ff.packet_last && !out_ff.is_channel_data,
      out_ff.frame_length >= StunHeaderBytes)
   // Padding only runs between packets
   `STTD_ASSERT_IMP(a_pad_between, pad_remaining_ff != 2'd0, byte_position_ff == '0)
   // A dropped pad byte never produces a result
   `STTD_ASSERT_NEXT(a_pad_silent,
      advance && drop && !(out_valid_ff && !rsp_ready), !out_valid_ff)

endmodule
